@@ rtl/psh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package psh_pkg;

  localparam int unsigned ImageW = 16;
  localparam int unsigned HashW = 64;
  localparam int unsigned HalfW = HashW / 2;
  localparam int unsigned DegW = 17;
  localparam int unsigned PendDepth = 3;
  localparam int unsigned PendIdxW = 2;

  localparam logic [HashW-1:0] SeedBasis = 64'd1469598103934665603;
  localparam logic [HashW-1:0] FnvPrime = 64'd1099511628211;
  localparam logic [HashW-1:0] MixMulA = 64'hbf58476d1ce4e5b9;
  localparam logic [HashW-1:0] MixMulB = 64'h94d049bb133111eb;
  localparam int unsigned MixShift1 = 30;
  localparam int unsigned MixShift2 = 27;
  localparam int unsigned MixShift3 = 31;

  localparam logic [DegW-1:0] MaxDegree = 17'd65536;
  localparam logic [DegW-1:0] CountMax = 17'd131071;

  typedef struct packed {
    logic             start;
    logic [HashW-1:0] a;
    logic [HashW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [HashW-1:0] p;
  } mul_rsp_t;

endpackage
`default_nettype wire

@@ rtl/psh_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface psh_in_if;
  logic                        valid;
  logic                        ready;
  logic [psh_pkg::ImageW-1:0]  image;
  logic                        last;

  modport source (output valid, output image, output last, input ready);
  modport sink (input valid, input image, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/psh_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface psh_out_if;
  logic                       valid;
  logic                       ready;
  logic [psh_pkg::HashW-1:0]  hash;
  logic                       too_long;

  modport source (output valid, output hash, output too_long, input ready);
  modport sink (input valid, input hash, input too_long, output ready);
endinterface
`default_nettype wire

@@ rtl/psh_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// 64x64 -> low 64 bits product with one 32x32 multiplier, three partial
// products accumulated one per step. done pulses the cycle after the last step.
module psh_mul (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire psh_pkg::mul_req_t req,
  output psh_pkg::mul_rsp_t      rsp
);

  logic [psh_pkg::HashW-1:0] a_q;
  logic [psh_pkg::HashW-1:0] b_q;
  logic [psh_pkg::HashW-1:0] p_q;
  logic [1:0]                step;
  logic                      busy;
  logic                      done_q;

  logic [psh_pkg::HalfW-1:0] m_x;
  logic [psh_pkg::HalfW-1:0] m_y;
  logic [psh_pkg::HashW-1:0] prod;
  logic [psh_pkg::HashW-1:0] addend;

  always_comb begin
    unique case (step)
      2'd0: begin
        m_x = a_q[psh_pkg::HalfW-1:0];
        m_y = b_q[psh_pkg::HalfW-1:0];
      end
      2'd1: begin
        m_x = a_q[psh_pkg::HalfW-1:0];
        m_y = b_q[psh_pkg::HashW-1:psh_pkg::HalfW];
      end
      2'd2: begin
        m_x = a_q[psh_pkg::HashW-1:psh_pkg::HalfW];
        m_y = b_q[psh_pkg::HalfW-1:0];
      end
      default: begin
        m_x = '0;
        m_y = '0;
      end
    endcase
  end

  assign prod = {{psh_pkg::HalfW{1'b0}}, m_x} * {{psh_pkg::HalfW{1'b0}}, m_y};
  // cross terms only reach the upper half
  assign addend = (step == 2'd0) ? prod
                                 : {prod[psh_pkg::HalfW-1:0], {psh_pkg::HalfW{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_q <= 1'b0;
      step   <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (req.start && !busy) begin
        a_q  <= req.a;
        b_q  <= req.b;
        p_q  <= '0;
        step <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        p_q  <= p_q + addend;
        step <= step + 2'd1;
        if (step == 2'd2) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_q;
  assign rsp.p    = p_q;

endmodule
`default_nettype wire

@@ rtl/permutation_stream_hash.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Streaming permutation hash (FNV-1a style fold, splitmix64 finalizer).
// data:   one 16-bit image per item in index order, last marks the final one.
// result: one item per permutation carrying the 64-bit hash and too_long.
// Every fold is a 64-bit multiply done on one shared 32x32 multiplier in
// three passes.
// An item that only joins the pending group leaves the sequencer idle; an
// item that completes a group of four holds it for the xor and multiply.
// A last item runs 0 to 3 tail folds, the degree fold and the two
// finalizer multiplies before the result is loaded.
// data.ready is high only while the sequencer is idle.
// The result register decouples the two sides: new items are accepted while
// a result waits; if the next result is ready first, the sequencer holds it
// until result.ready drains the register.
// Synchronous reset (rst) returns the accumulator to its seed, clears the
// counts and empties the result register.
module permutation_stream_hash (
  input  wire logic  clk,
  input  wire logic  rst,
  psh_in_if.sink     data,
  psh_out_if.source  result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WORD  = 3'd1;
  localparam logic [2:0] S_TAIL  = 3'd2;
  localparam logic [2:0] S_TAILW = 3'd3;
  localparam logic [2:0] S_DEGW  = 3'd4;
  localparam logic [2:0] S_MULA  = 3'd5;
  localparam logic [2:0] S_MULB  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]                  state;
  logic [psh_pkg::HashW-1:0]   acc;
  logic [psh_pkg::ImageW-1:0]  pend [psh_pkg::PendDepth];
  logic [psh_pkg::PendIdxW-1:0] pcount;
  logic [psh_pkg::PendIdxW-1:0] k;
  logic [psh_pkg::DegW-1:0]    deg;
  logic                        ovf;
  logic                        last_q;
  logic [psh_pkg::HashW-1:0]   fin;

  logic                        out_valid;
  logic [psh_pkg::HashW-1:0]   out_hash;
  logic                        out_too_long;

  psh_pkg::mul_req_t           mreq;
  psh_pkg::mul_rsp_t           mrsp;

  logic                        accept;
  logic [psh_pkg::DegW-1:0]    deg_next;
  logic [psh_pkg::HashW-1:0]   word;
  logic [psh_pkg::HashW-1:0]   mix1;
  logic [psh_pkg::HashW-1:0]   mix2;
  logic                        load_out;

  psh_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign data.ready = (state == S_IDLE);
  assign accept     = data.valid && data.ready;
  assign deg_next   = (deg < psh_pkg::CountMax) ? deg + 1'b1 : deg;
  assign word       = {data.image, pend[2], pend[1], pend[0]};
  assign mix1       = mrsp.p ^ (mrsp.p >> psh_pkg::MixShift1);
  assign mix2       = mrsp.p ^ (mrsp.p >> psh_pkg::MixShift2);
  assign load_out   = (state == S_EMIT) && (!out_valid || result.ready);

  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = acc;
    mreq.b     = psh_pkg::FnvPrime;
    unique case (state)
      S_IDLE: begin
        mreq.start = accept && (pcount == 2'd3);
        mreq.a     = acc ^ word;
      end
      S_TAIL: begin
        mreq.start = 1'b1;
        mreq.a     = (k < pcount) ? (acc ^ {48'd0, pend[k]})
                                  : (acc ^ {47'd0, deg});
      end
      S_DEGW: begin
        mreq.start = mrsp.done;
        mreq.a     = mix1;
        mreq.b     = psh_pkg::MixMulA;
      end
      S_MULA: begin
        mreq.start = mrsp.done;
        mreq.a     = mix2;
        mreq.b     = psh_pkg::MixMulB;
      end
      default: begin
        mreq.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      acc    <= psh_pkg::SeedBasis;
      pcount <= '0;
      k      <= '0;
      deg    <= '0;
      ovf    <= 1'b0;
      last_q <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            deg    <= deg_next;
            ovf    <= ovf || (deg_next > psh_pkg::MaxDegree);
            last_q <= data.last;
            k      <= '0;
            if (pcount == 2'd3) begin
              pcount <= '0;
              state  <= S_WORD;
            end else begin
              pend[pcount] <= data.image;
              pcount       <= pcount + 2'd1;
              if (data.last) begin
                state <= S_TAIL;
              end
            end
          end
        end
        S_WORD: begin
          if (mrsp.done) begin
            acc   <= mrsp.p;
            state <= last_q ? S_TAIL : S_IDLE;
          end
        end
        S_TAIL: begin
          state <= (k < pcount) ? S_TAILW : S_DEGW;
        end
        S_TAILW: begin
          if (mrsp.done) begin
            acc   <= mrsp.p;
            k     <= k + 2'd1;
            state <= S_TAIL;
          end
        end
        S_DEGW: begin
          if (mrsp.done) begin
            state <= S_MULA;
          end
        end
        S_MULA: begin
          if (mrsp.done) begin
            state <= S_MULB;
          end
        end
        S_MULB: begin
          if (mrsp.done) begin
            fin   <= mrsp.p ^ (mrsp.p >> psh_pkg::MixShift3);
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load_out) begin
            acc    <= psh_pkg::SeedBasis;
            pcount <= '0;
            deg    <= '0;
            ovf    <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid    <= 1'b1;
      out_hash     <= fin;
      out_too_long <= ovf;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid    = out_valid;
  assign result.hash     = out_hash;
  assign result.too_long = out_too_long;

endmodule
`default_nettype wire

@@ rtl/psh_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
module psh_chk (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       in_last,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [psh_pkg::HashW-1:0]  out_hash
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_hash))
    else $error("result hash changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result register not empty after reset");

  a_rst_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("not ready for items after reset");

  // a last item always starts the finishing sequence
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("ready right after a last item");

endmodule

bind permutation_stream_hash psh_chk u_psh_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (data.valid),
  .in_ready  (data.ready),
  .in_last   (data.last),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_hash  (result.hash)
);
`default_nettype wire

@@ dv/psh_hash_checker.sv @@
`timescale 1ns / 1ps
module psh_hash_checker (
  input wire logic clk,
  input wire logic rst,
  psh_in_if        data,
  psh_out_if       result,
  output int       errors,
  output int       due
);

  // hash constants, independent of the RTL package
  localparam logic [63:0] HashSeed = 64'd1469598103934665603;
  localparam logic [63:0] FoldPrime = 64'd1099511628211;
  localparam logic [63:0] MixA = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixB = 64'h94d049bb133111eb;
  localparam logic [16:0] DegreeLimit = 17'd65536;
  localparam logic [16:0] DegreeCeiling = 17'h1ffff;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [psh_pkg::HashW-1:0] hash;
    logic                      too_long;
  } hash_item_t;

  hash_item_t                 expected_hashes[$];
  logic [psh_pkg::HashW-1:0]  acc;
  logic [psh_pkg::ImageW-1:0] held [3];
  int                         held_cnt;
  logic [psh_pkg::DegW-1:0]   degree;
  logic                       overflow;
  int                         mismatches = 0;
  int                         waiting = 0;

  assign errors = mismatches;
  assign due = waiting;

  function automatic logic [psh_pkg::HashW-1:0] fnv_fold(
      input logic [psh_pkg::HashW-1:0] a, input logic [psh_pkg::HashW-1:0] v);
    return (a ^ v) * FoldPrime;
  endfunction

  function automatic logic [psh_pkg::HashW-1:0] mix64(input logic [psh_pkg::HashW-1:0] v);
    logic [psh_pkg::HashW-1:0] m;
    m = v ^ (v >> 30);
    m = m * MixA;
    m = m ^ (m >> 27);
    m = m * MixB;
    return m ^ (m >> 31);
  endfunction

  task automatic clear_hash_state();
    acc = HashSeed;
    held[0] = '0;
    held[1] = '0;
    held[2] = '0;
    held_cnt = 0;
    degree = '0;
    overflow = 1'b0;
  endtask

  task automatic absorb_image(input logic [psh_pkg::ImageW-1:0] img, input logic fin);
    hash_item_t h;
    int k;
    if (degree != DegreeCeiling) degree = degree + 1'b1;
    if (degree > DegreeLimit) overflow = 1'b1;
    if (held_cnt == 3) begin
      // first image sits in the low bits of the word
      acc = fnv_fold(acc, {img, held[2], held[1], held[0]});
      held_cnt = 0;
    end else begin
      held[held_cnt] = img;
      held_cnt++;
    end
    if (fin) begin
      for (k = 0; k < held_cnt; k++) acc = fnv_fold(acc, {48'd0, held[k]});
      acc = fnv_fold(acc, {47'd0, degree});
      h.hash = mix64(acc);
      h.too_long = overflow;
      expected_hashes.push_back(h);
      clear_hash_state();
    end
  endtask

  task automatic check_result(input logic [psh_pkg::HashW-1:0] hash, input logic too_long);
    hash_item_t h;
    if (expected_hashes.size() == 0) begin
      if (mismatches < ReportLimit)
        $display("%0t: unexpected result hash=%h too_long=%b", $time, hash, too_long);
      mismatches++;
    end else begin
      h = expected_hashes.pop_front();
      if (hash !== h.hash || too_long !== h.too_long) begin
        if (mismatches < ReportLimit)
          $display("%0t: mismatch hash exp=%h got=%h too_long exp=%b got=%b",
                   $time, h.hash, hash, h.too_long, too_long);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_hash_state();
      expected_hashes.delete();
    end else begin
      if (data.valid && data.ready) absorb_image(data.image, data.last);
      if (result.valid && result.ready) check_result(result.hash, result.too_long);
    end
    waiting <= expected_hashes.size();
  end

endmodule

@@ dv/tb_permutation_stream_hash.sv @@
`timescale 1ns / 1ps
module tb_permutation_stream_hash;

  localparam int CycleLimit = 4000000;
  localparam int RandomImages = 1200;
  localparam int DrainCycles = 40;

  logic clk;
  logic rst;
  int   fail_count;
  int   hashes_due;
  int   cycle_count = 0;

  psh_in_if  data_ch ();
  psh_out_if result_ch ();

  permutation_stream_hash i_dut (
    .clk    (clk),
    .rst    (rst),
    .data   (data_ch),
    .result (result_ch)
  );

  psh_hash_checker i_checker (
    .clk    (clk),
    .rst    (rst),
    .data   (data_ch),
    .result (result_ch),
    .errors (fail_count),
    .due    (hashes_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(4, 30);
  endfunction

  // called and returns at a falling edge
  task automatic push_image(input logic [psh_pkg::ImageW-1:0] img, input logic fin,
                            input int gap);
    if (gap > 0) begin
      data_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    data_ch.valid <= 1'b1;
    data_ch.image <= img;
    data_ch.last <= fin;
    @(posedge clk);
    while (!data_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_perm(input logic [psh_pkg::ImageW-1:0] imgs[$], input bit steady);
    int i;
    for (i = 0; i < imgs.size(); i++)
      push_image(imgs[i], i == imgs.size() - 1, steady ? 0 : pick_gap());
  endtask

  task automatic send_random_perm(output int n);
    logic [psh_pkg::ImageW-1:0] imgs[$];
    logic [psh_pkg::ImageW-1:0] tmp;
    int r;
    int kind;
    int i;
    int j;
    r = $urandom_range(0, 99);
    if (r < 70) n = $urandom_range(1, 8);
    else if (r < 95) n = $urandom_range(9, 40);
    else n = $urandom_range(41, 300);
    kind = $urandom_range(0, 9);
    for (i = 0; i < n; i++) begin
      if (kind < 5) imgs.push_back(i[15:0]);
      else if (kind < 8) imgs.push_back(16'($urandom));
      else begin
        case ($urandom_range(0, 3))
          0: imgs.push_back(16'h0000);
          1: imgs.push_back(16'hffff);
          2: imgs.push_back(16'h0001 << $urandom_range(0, 15));
          default: imgs.push_back(16'($urandom));
        endcase
      end
    end
    if (kind < 5) begin
      for (i = n - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = imgs[i];
        imgs[i] = imgs[j];
        imgs[j] = tmp;
      end
    end
    send_perm(imgs, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    int r;
    int n;
    result_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    @(negedge clk);
    forever begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(50, 300)) @(negedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          result_ch.ready <= 1'b0;
          repeat (n) @(negedge clk);
        end
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
    end
  end

  initial begin
    logic [psh_pkg::ImageW-1:0] dir[$];
    int n;
    int sent;
    rst = 1'b1;
    data_ch.valid = 1'b0;
    data_ch.image = '0;
    data_ch.last = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // single images, short tails, exact groups and a group plus tail
    dir = '{16'h0000};
    send_perm(dir, 1'b1);
    dir = '{16'hffff};
    send_perm(dir, 1'b1);
    dir = '{16'h0001, 16'h0000};
    send_perm(dir, 1'b0);
    dir = '{16'hffff, 16'hffff, 16'hffff};
    send_perm(dir, 1'b1);
    dir = '{16'h0003, 16'h0001, 16'h0000, 16'h0002};
    send_perm(dir, 1'b0);
    dir = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0000};
    send_perm(dir, 1'b1);
    dir = '{16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0006};
    send_perm(dir, 1'b0);
    dir = '{16'h8000, 16'h4000, 16'h2000, 16'h1000, 16'h0800, 16'h0400, 16'h0200,
            16'h0100};
    send_perm(dir, 1'b1);

    sent = 0;
    while (sent < RandomImages) begin
      send_random_perm(n);
      sent += n;
    end
    data_ch.valid <= 1'b0;

    wait (hashes_due == 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && hashes_due == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
